[rtl/rbfk_pkg.sv]
package rbfk_pkg;

    localparam int MAX_VECTORS = 256;
    localparam int MAX_DIMS    = 64;
    localparam int VEC_W       = $clog2(MAX_VECTORS);
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int ADDR_W      = VEC_W + DIM_W;
    localparam int STORE_DEPTH = MAX_VECTORS * MAX_DIMS;

    localparam int FEAT_W  = 16;
    localparam int GAMMA_W = 24;
    localparam int DIMS_W  = 7;
    localparam int VIU_W   = 9;
    localparam int KERN_W  = 17;
    localparam int CFG_W   = 24;

    // Squared distance: up to MAX_DIMS squares, each below 2^32.
    localparam int D2_W   = 32 + DIM_W;
    localparam int D2_LO  = D2_W / 2;
    localparam int D2_HI  = D2_W - D2_LO;
    localparam int X_W    = D2_W + GAMMA_W;
    localparam int SUM_W  = 35;
    localparam int E_W    = 33;

    localparam logic [31:0] EXP_NEG_ONE_Q32 = 32'd1580030169;
    localparam logic [3:0]  LAST_TERM       = 4'd12;

    localparam logic [1:0] CFG_GAMMA  = 2'd0;
    localparam logic [1:0] CFG_DIMS   = 2'd1;
    localparam logic [1:0] CFG_VIU    = 2'd2;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             start;
        logic             rd;
        logic [DIM_W-1:0] elem;
        logic             sq;
        logic             acc;
        logic             mul;
        logic             xsum;
        logic             tinit;
        logic             tmul;
        logic             tdiv;
        logic             tcor;
        logic [3:0]       k;
        logic             eclamp;
        logic             emul;
        logic             eshift;
        logic             out;
    } t_dp_cmd;

    typedef struct packed {
        logic       err;
        logic       gamma_zero;
        logic       big;
        logic [3:0] n;
    } t_dp_stat;

    // floor(2^32 / k); the quotient from it is low by at most one.
    function automatic logic [31:0] recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'hFFFFFFFF;
            4'd2:    r = 32'h80000000;
            4'd3:    r = 32'h55555555;
            4'd4:    r = 32'h40000000;
            4'd5:    r = 32'h33333333;
            4'd6:    r = 32'h2AAAAAAA;
            4'd7:    r = 32'h24924924;
            4'd8:    r = 32'h20000000;
            4'd9:    r = 32'h1C71C71C;
            4'd10:   r = 32'h19999999;
            4'd11:   r = 32'h1745D174;
            4'd12:   r = 32'h15555555;
            default: r = 32'hFFFFFFFF;
        endcase
        return r;
    endfunction

endpackage

[rtl/rbfk_ram.sv]
module rbfk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/rbfk_dp.sv]
module rbfk_dp
    import rbfk_pkg::*;
(
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_load,
    input  logic [VEC_W-1:0]   i_vector_index,
    input  logic [DIM_W-1:0]   i_element_index,
    input  logic [FEAT_W-1:0]  i_feature_value,
    input  logic [VEC_W-1:0]   i_column_index,
    input  logic [GAMMA_W-1:0] i_gamma,
    input  logic [VIU_W-1:0]   i_vectors_in_use,
    output logic [KERN_W-1:0]  o_kernel_value,
    output logic [VIU_W-1:0]   o_row_id,
    output logic               o_status
);

    logic [VEC_W-1:0]   r_row, r_col;
    logic [FEAT_W-1:0]  rd_a, rd_b;
    logic [31:0]        r_sq;
    logic [D2_W-1:0]    r_d2;
    logic [D2_LO+GAMMA_W-1:0] r_pl;
    logic [D2_HI+GAMMA_W-1:0] r_ph;
    logic [X_W-1:0]     r_x;
    logic [31:0]        r_term, r_p, r_q;
    logic signed [SUM_W-1:0] r_sum;
    logic [E_W-1:0]     r_e;
    logic [E_W+31:0]    r_eprod;

    logic [VIU_W-1:0]   limit;
    logic               err;
    logic signed [FEAT_W:0] diff;
    logic signed [2*FEAT_W+1:0] sq_full;
    logic [31:0]        f;
    logic [63:0]        tprod, qprod;
    logic [31:0]        rem, qc;
    logic [E_W+32:0]    eround;
    logic [E_W:0]       kround;
    logic [X_W-47:0]    x_int;

    rbfk_ram #(.WIDTH(FEAT_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_we      (i_load),
        .i_waddr   ({i_vector_index, i_element_index}),
        .i_wdata   (i_feature_value),
        .i_raddr_a ({r_row, i_cmd.elem}),
        .i_raddr_b ({r_col, i_cmd.elem}),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        limit = (i_vectors_in_use > VIU_W'(MAX_VECTORS)) ? VIU_W'(MAX_VECTORS)
                                                         : i_vectors_in_use;
        err = (VIU_W'(r_row) >= limit) || (VIU_W'(r_col) >= limit);
        diff = $signed({rd_a[FEAT_W-1], rd_a}) - $signed({rd_b[FEAT_W-1], rd_b});
        sq_full = diff * diff;
        f = r_x[45:14];
        tprod = 64'(r_term) * 64'(f);
        qprod = 64'(r_p) * 64'(recip(i_cmd.k));
        rem = r_p - 32'(r_q * 32'(i_cmd.k));
        qc = (rem >= 32'(i_cmd.k)) ? r_q + 32'd1 : r_q;
        eround = {1'b0, r_eprod} + (E_W+33)'(64'h80000000);
        kround = {1'b0, r_e} + (E_W+1)'(32'h8000);
        x_int = r_x[X_W-1:46];
        o_stat.err = err;
        o_stat.gamma_zero = (i_gamma == '0);
        o_stat.big = (x_int >= (X_W-46)'(12));
        o_stat.n = x_int[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= i_vector_index;
            r_col <= i_column_index;
            r_d2  <= '0;
        end
        if (i_cmd.sq) begin
            r_sq <= sq_full[31:0];
        end
        if (i_cmd.acc) begin
            r_d2 <= r_d2 + D2_W'(r_sq);
        end
        if (i_cmd.mul) begin
            r_pl <= (D2_LO+GAMMA_W)'(r_d2[D2_LO-1:0]) * (D2_LO+GAMMA_W)'(i_gamma);
            r_ph <= (D2_HI+GAMMA_W)'(r_d2[D2_W-1:D2_LO]) * (D2_HI+GAMMA_W)'(i_gamma);
        end
        if (i_cmd.xsum) begin
            r_x <= X_W'(r_pl) + (X_W'(r_ph) << D2_LO);
        end
        // The first Taylor term is f itself; the sum starts at 1 - f.
        if (i_cmd.tinit) begin
            r_term <= f;
            r_sum  <= (SUM_W'(64'h100000000)) - SUM_W'(f);
        end
        if (i_cmd.tmul) begin
            r_p <= tprod[63:32];
        end
        if (i_cmd.tdiv) begin
            r_q <= qprod[63:32];
        end
        if (i_cmd.tcor) begin
            r_term <= qc;
            if (i_cmd.k[0]) begin
                r_sum <= r_sum - SUM_W'(qc);
            end else begin
                r_sum <= r_sum + SUM_W'(qc);
            end
        end
        if (i_cmd.eclamp) begin
            r_e <= r_sum[SUM_W-1] ? '0 : r_sum[E_W-1:0];
        end
        if (i_cmd.emul) begin
            r_eprod <= (E_W+32)'(r_e) * (E_W+32)'(EXP_NEG_ONE_Q32);
        end
        if (i_cmd.eshift) begin
            r_e <= eround[E_W+31:32];
        end
        if (i_cmd.out) begin
            o_row_id <= VIU_W'(r_row) + VIU_W'(1);
            o_status <= err;
            if (err || (!o_stat.gamma_zero && o_stat.big)) begin
                o_kernel_value <= '0;
            end else if (o_stat.gamma_zero) begin
                o_kernel_value <= KERN_W'(65536);
            end else begin
                o_kernel_value <= kround[E_W-1:16];
            end
        end
    end

endmodule

[rtl/rbfk_ctrl.sv]
module rbfk_ctrl
    import rbfk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [DIMS_W-1:0] i_dims,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DIST   = 13'b0000000000010,
        S_DRAIN  = 13'b0000000000100,
        S_MUL    = 13'b0000000001000,
        S_XSUM   = 13'b0000000010000,
        S_TINIT  = 13'b0000000100000,
        S_TMUL   = 13'b0000001000000,
        S_TDIV   = 13'b0000010000000,
        S_TCOR   = 13'b0000100000000,
        S_ECLAMP = 13'b0001000000000,
        S_EMUL   = 13'b0010000000000,
        S_ESHIFT = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [DIMS_W-1:0] r_elem, n_elem;
    logic [3:0]        r_k, n_k;
    logic [3:0]        r_ncnt, n_ncnt;
    logic [1:0]        r_pipe, n_pipe;
    logic              r_valid, n_valid;
    logic [DIMS_W-1:0] eff_dims;
    logic              out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    always_comb begin
        eff_dims = (i_dims > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : i_dims;
        out_free = !r_valid || !i_out_stall;
        n_state = r_state;
        n_elem  = r_elem;
        n_k     = r_k;
        n_ncnt  = r_ncnt;
        n_valid = (r_valid && !i_out_stall) ? 1'b0 : r_valid;
        o_cmd = '0;
        o_cmd.elem = r_elem[DIM_W-1:0];
        o_cmd.k    = r_k;
        o_cmd.sq   = r_pipe[0];
        o_cmd.acc  = r_pipe[1];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_operation == OP_QUERY) begin
                    o_cmd.start = 1'b1;
                    n_elem  = '0;
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                if (i_stat.err) begin
                    n_state = S_OUT;
                end else if (r_elem < eff_dims) begin
                    o_cmd.rd = 1'b1;
                    n_elem = r_elem + DIMS_W'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_pipe == 2'b00) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_XSUM;
            end
            S_XSUM: begin
                o_cmd.xsum = 1'b1;
                n_state = S_TINIT;
            end
            S_TINIT: begin
                if (i_stat.gamma_zero || i_stat.big) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.tinit = 1'b1;
                    n_k    = 4'd2;
                    n_ncnt = i_stat.n;
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                o_cmd.tmul = 1'b1;
                n_state = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.tdiv = 1'b1;
                n_state = S_TCOR;
            end
            S_TCOR: begin
                o_cmd.tcor = 1'b1;
                if (r_k == LAST_TERM) begin
                    n_state = S_ECLAMP;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = S_TMUL;
                end
            end
            S_ECLAMP: begin
                o_cmd.eclamp = 1'b1;
                n_state = (r_ncnt == 4'd0) ? S_OUT : S_EMUL;
            end
            S_EMUL: begin
                o_cmd.emul = 1'b1;
                n_state = S_ESHIFT;
            end
            S_ESHIFT: begin
                o_cmd.eshift = 1'b1;
                n_ncnt = r_ncnt - 4'd1;
                n_state = (r_ncnt == 4'd1) ? S_OUT : S_EMUL;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_pipe = {r_pipe[0], o_cmd.rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pipe  <= 2'b00;
            r_elem  <= '0;
            r_k     <= 4'd2;
            r_ncnt  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pipe  <= n_pipe;
            r_elem  <= n_elem;
            r_k     <= n_k;
            r_ncnt  <= n_ncnt;
        end
    end

    // A finished result never overwrites one that is still being held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out |-> (!r_valid || !i_out_stall))
        else $error("result loaded over a stalled result");

    // The series index stays within the thirteen terms.
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TMUL || r_state == S_TDIV || r_state == S_TCOR)
        |-> (r_k >= 4'd2 && r_k <= LAST_TERM))
        else $error("Taylor term index out of range");

    // The distance sum is complete before gamma is applied.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul |-> (r_pipe == 2'b00 && $past(r_state) == S_DRAIN))
        else $error("distance pipeline not drained");

endmodule

[rtl/rbf_kernel_matrix_core.sv]
// Gaussian RBF kernel matrix unit.
// Input channel (i_in_valid / o_in_stall): an item either loads one feature
// element (operation 0) into the vector store or queries the kernel entry of
// a row vector and a column vector (operation 1). Loads give no result.
// A query walks every feature element in use through one squaring and
// accumulate pipeline, one element per cycle, then scales the squared
// distance by gamma and evaluates the exponential as a series on the fraction
// of the product, multiplied by exp(-1) once for each unit of its integer
// part (at most 11). A zero gamma or a saturated argument skips the series,
// and an index error skips the distance as well. The input is stalled while
// a query is in progress. Output channel (o_out_valid / i_out_stall): one
// item per query, held in an output register; the next query may proceed
// while it waits, and only its final write waits for the register to be
// taken. Configuration writes go straight to the registers; the user must
// make them only while idle, which the block itself does not enforce. Reset
// sets gamma to 1.0 and both counts to their maximum; the feature store is
// not cleared and must be loaded before it is queried.
module rbf_kernel_matrix_core
    import rbfk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [VEC_W-1:0]   i_vector_index,
    input  logic [DIM_W-1:0]   i_element_index,
    input  logic [FEAT_W-1:0]  i_feature_value,
    input  logic [VEC_W-1:0]   i_column_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [KERN_W-1:0]  o_kernel_value,
    output logic [VIU_W-1:0]   o_row_id,
    output logic               o_status
);

    logic [GAMMA_W-1:0] r_gamma;
    logic [DIMS_W-1:0]  r_dims;
    logic [VIU_W-1:0]   r_viu;
    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic               load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_W'(65536);
            r_dims  <= DIMS_W'(64);
            r_viu   <= VIU_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAMMA: r_gamma <= i_cfg_data[GAMMA_W-1:0];
                CFG_DIMS:  r_dims  <= i_cfg_data[DIMS_W-1:0];
                CFG_VIU:   r_viu   <= i_cfg_data[VIU_W-1:0];
                default:   ;
            endcase
        end
    end

    assign load = i_in_valid && !o_in_stall && (i_operation == OP_LOAD);

    rbfk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_dims      (r_dims),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rbfk_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_load           (load),
        .i_vector_index   (i_vector_index),
        .i_element_index  (i_element_index),
        .i_feature_value  (i_feature_value),
        .i_column_index   (i_column_index),
        .i_gamma          (r_gamma),
        .i_vectors_in_use (r_viu),
        .o_kernel_value   (o_kernel_value),
        .o_row_id         (o_row_id),
        .o_status         (o_status)
    );

endmodule

[tb/rbfk_checker.sv]
`timescale 1ns / 1ps

module rbfk_checker
    import rbfk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_operation,
    input  logic [VEC_W-1:0]  i_vector_index,
    input  logic [DIM_W-1:0]  i_element_index,
    input  logic [FEAT_W-1:0] i_feature_value,
    input  logic [VEC_W-1:0]  i_column_index,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [KERN_W-1:0] i_kernel_value,
    input  logic [VIU_W-1:0]  i_row_id,
    input  logic              i_status,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [KERN_W-1:0] kernel;
        logic [VIU_W-1:0]  row_id;
        logic              status;
    } t_kernel_entry;

    logic [FEAT_W-1:0] feature_mem [STORE_DEPTH];
    logic [GAMMA_W-1:0] gamma_q;
    logic [DIMS_W-1:0]  dims_q;
    logic [VIU_W-1:0]   viu_q;
    t_kernel_entry      expected_kernels [$];

    // exp(-x) for x in Q.46, rounded to Q1.16.
    function automatic logic [KERN_W-1:0] exp_neg(input longint unsigned x);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        n    = x >> 46;
        f    = (x & ((64'd1 << 46) - 1)) >> 14;
        term = 64'h1_0000_0000;
        sum  = 64'h1_0000_0000;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * f) >> 32) / k;
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = longint'(sum);
        for (longint unsigned i = 0; i < n; i++) begin
            e = (e * 64'(EXP_NEG_ONE_Q32) + (64'd1 << 31)) >> 32;
        end
        return KERN_W'((e + (64'd1 << 15)) >> 16);
    endfunction

    function automatic t_kernel_entry predict_query(input logic [VEC_W-1:0] row,
                                                    input logic [VEC_W-1:0] col);
        t_kernel_entry r;
        int unsigned dims;
        int unsigned lim;
        longint unsigned d2;
        longint unsigned x;
        longint a;
        longint b;
        dims = (dims_q < MAX_DIMS) ? dims_q : MAX_DIMS;
        lim  = (viu_q < MAX_VECTORS) ? viu_q : MAX_VECTORS;
        r.row_id = VIU_W'(row) + 1'b1;
        if (row >= lim || col >= lim) begin
            r.kernel = '0;
            r.status = 1'b1;
            return r;
        end
        r.status = 1'b0;
        d2 = 0;
        for (int i = 0; i < dims; i++) begin
            a  = longint'($signed(feature_mem[row * MAX_DIMS + i]));
            b  = longint'($signed(feature_mem[col * MAX_DIMS + i]));
            d2 = d2 + longint'((a - b) * (a - b));
        end
        // d2 stays below 2^39 and gamma below 2^24, so the product fits.
        x = d2 * gamma_q;
        if (gamma_q == 0) begin
            r.kernel = KERN_W'(65536);
        end else if (x >= (64'd12 << 46)) begin
            r.kernel = '0;
        end else begin
            r.kernel = exp_neg(x);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_kernel_entry want;
        if (!i_rst_n) begin
            gamma_q <= GAMMA_W'(65536);
            dims_q  <= DIMS_W'(64);
            viu_q   <= VIU_W'(256);
            expected_kernels.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAMMA: gamma_q <= i_cfg_data[GAMMA_W-1:0];
                    CFG_DIMS:  dims_q  <= i_cfg_data[DIMS_W-1:0];
                    CFG_VIU:   viu_q   <= i_cfg_data[VIU_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_kernels.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result: kernel %0d row_id %0d status %0d",
                                 i_kernel_value, i_row_id, i_status);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_kernels.pop_front();
                    if (want.kernel !== i_kernel_value || want.row_id !== i_row_id ||
                        want.status !== i_status) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: kernel %0d/%0d row_id %0d/%0d status %0d/%0d",
                                     want.kernel, i_kernel_value, want.row_id, i_row_id,
                                     want.status, i_status);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_LOAD) begin
                    feature_mem[i_vector_index * MAX_DIMS + i_element_index] = i_feature_value;
                end else begin
                    expected_kernels.push_back(predict_query(i_vector_index, i_column_index));
                end
            end
        end
        o_pending <= expected_kernels.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rbfk_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_operation;
    logic [VEC_W-1:0]  i_vector_index;
    logic [DIM_W-1:0]  i_element_index;
    logic [FEAT_W-1:0] i_feature_value;
    logic [VEC_W-1:0]  i_column_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [KERN_W-1:0] o_kernel_value;
    logic [VIU_W-1:0]  o_row_id;
    logic              o_status;

    int fail_count;
    int pending;
    int results_seen;
    bit quiet;
    bit written [MAX_VECTORS][MAX_DIMS];
    int loaded_pool [$];
    int unsigned dims_set;
    int unsigned viu_set;

    rbf_kernel_matrix_core dut (.*);

    rbfk_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_operation, .i_vector_index,
        .i_element_index, .i_feature_value, .i_column_index,
        .i_out_valid(o_out_valid), .i_out_stall, .i_kernel_value(o_kernel_value),
        .i_row_id(o_row_id), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #40ms;
        $display("** rbf_kernel_matrix_core: FAILED **");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            results_seen <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
        end
    end

    // Receiver: one long hold-off once results flow, random stalls otherwise.
    initial begin
        int stall_left;
        bit held;
        stall_left = 0;
        held = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 30) begin
                held = 1;
                i_out_stall = 1'b1;
                repeat (600) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
                stall_left = idle_len();
            end
        end
    end

    task automatic send_item(input logic op, input int vec, input int elem,
                             input logic [FEAT_W-1:0] val, input int col);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_operation     = op;
        i_vector_index  = VEC_W'(vec);
        i_element_index = DIM_W'(elem);
        i_feature_value = val;
        i_column_index  = VEC_W'(col);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_LOAD) written[vec][elem] = 1;
    endtask

    task automatic load_vector(input int vec, input int mode);
        logic [FEAT_W-1:0] v;
        for (int e = 0; e < MAX_DIMS; e++) begin
            case (mode)
                0:       v = 16'h8000;
                1:       v = 16'h7FFF;
                2:       v = 16'h8000 + FEAT_W'($urandom_range(0, 15));
                default: v = FEAT_W'($urandom_range(0, 511) - 256);
            endcase
            send_item(OP_LOAD, vec, e, v, $urandom_range(0, 255));
        end
        loaded_pool.push_back(vec);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == CFG_DIMS) dims_set = data & 7'h7F;
        if (idx == CFG_VIU) viu_set = data & 9'h1FF;
    endtask

    // Waits until every query has answered, then lets any trailing work finish.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // True when a query would touch an element that was never loaded.
    function automatic bit reads_unwritten(input int row, input int col);
        int unsigned dims;
        int unsigned lim;
        dims = (dims_set < MAX_DIMS) ? dims_set : MAX_DIMS;
        lim  = (viu_set < MAX_VECTORS) ? viu_set : MAX_VECTORS;
        if (row >= lim || col >= lim) return 0;
        for (int i = 0; i < dims; i++) begin
            if (!written[row][i] || !written[col][i]) return 1;
        end
        return 0;
    endfunction

    task automatic random_item();
        int row;
        int col;
        int elem;
        logic [FEAT_W-1:0] v;
        if ($urandom_range(0, 99) < 55) begin
            row = ($urandom_range(0, 9) < 7) ? loaded_pool[$urandom_range(0, 7)]
                                             : $urandom_range(0, 255);
            col = ($urandom_range(0, 9) < 7) ? loaded_pool[$urandom_range(0, 7)]
                                             : $urandom_range(0, 255);
            if (reads_unwritten(row, col)) begin
                row = loaded_pool[$urandom_range(0, 7)];
                col = loaded_pool[$urandom_range(0, 7)];
            end
            send_item(OP_QUERY, row, $urandom_range(0, 63), FEAT_W'($urandom), col);
        end else begin
            row  = ($urandom_range(0, 9) < 7) ? loaded_pool[$urandom_range(0, 7)]
                                              : $urandom_range(0, 255);
            elem = $urandom_range(0, 63);
            v = ($urandom_range(0, 1) == 0) ? FEAT_W'($urandom)
                                            : FEAT_W'($urandom_range(0, 511) - 256);
            send_item(OP_LOAD, row, elem, v, $urandom_range(0, 255));
        end
    endtask

    initial begin
        int unsigned g;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_GAMMA;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_operation     = OP_LOAD;
        i_vector_index  = '0;
        i_element_index = '0;
        i_feature_value = '0;
        i_column_index  = '0;
        dims_set = 64;
        viu_set  = 256;
        quiet    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Most negative and most positive vectors, a near neighbor, small ones.
        load_vector(0, 0);
        load_vector(255, 1);
        load_vector(1, 2);
        for (int v = 2; v < 4; v++) load_vector(v, 3);
        for (int v = 252; v < 255; v++) load_vector(v, 3);

        send_item(OP_QUERY, 0, 0, '0, 0);
        send_item(OP_QUERY, 0, 255, '0, 255);
        send_item(OP_QUERY, 255, 0, '1, 0);
        send_item(OP_QUERY, 0, 1, '0, 1);
        send_item(OP_QUERY, 2, 3, '0, 3);
        send_item(OP_QUERY, 254, 253, '0, 252);
        settle();

        // Index errors, zero-length distance, gamma of zero and of its maximum.
        write_reg(CFG_VIU, 4);
        write_reg(CFG_DIMS, 0);
        write_reg(CFG_GAMMA, 24'hFFFFFF);
        write_reg(CFG_UNUSED, 24'h00ABCD);
        send_item(OP_QUERY, 3, 0, '0, 4);
        send_item(OP_QUERY, 255, 0, '0, 255);
        send_item(OP_QUERY, 0, 255, '0, 2);
        send_item(OP_QUERY, 0, 255, '0, 1);
        settle();
        write_reg(CFG_VIU, 0);
        write_reg(CFG_GAMMA, 0);
        write_reg(CFG_DIMS, 127);
        send_item(OP_QUERY, 0, 0, '0, 0);
        settle();
        write_reg(CFG_VIU, 511);
        send_item(OP_QUERY, 0, 0, '0, 255);
        send_item(OP_QUERY, 1, 0, '0, 0);
        settle();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: g = $urandom_range(1, 4000);
                1: g = 65536;
                2: g = $urandom_range(0, 16777215);
                default: g = $urandom_range(0, 1) ? 0 : $urandom_range(1, 200);
            endcase
            write_reg(CFG_GAMMA, g | ($urandom_range(0, 1) ? 0 : 0));
            write_reg(CFG_DIMS, (phase == 5) ? 1 : (phase == 9) ? 127 : $urandom_range(0, 64));
            write_reg(CFG_VIU, (phase == 3) ? 1 : (phase == 7) ? 256 :
                               (phase == 11) ? 511 : $urandom_range(1, 260));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 124; n++) random_item();
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** rbf_kernel_matrix_core: PASSED **");
        end else begin
            $display("** rbf_kernel_matrix_core: FAILED **");
        end
        $finish;
    end

endmodule
